@@ rtl/core/lstm_cell_step_core_macros.svh @@
// Assertion helpers shared by the LSTM step core.
`ifndef LSTM_CELL_STEP_CORE_MACROS_SVH
`define LSTM_CELL_STEP_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lstm core check failed");

// Next-cycle implication, held off during reset.
`define LCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lstm core check failed");

`endif

@@ rtl/core/lcs_pkg.sv @@
package lcs_pkg;

  localparam int INPUT_COUNT_DEF     = 6;
  localparam int HIDDEN_COUNT_DEF    = 16;
  localparam int ACT_TABLE_DEPTH_DEF = 256;

  localparam int DATA_W = 16;
  localparam int UNIT_W = 6;
  localparam int ROW_W  = 7;
  localparam int ACC_W  = 40;

  localparam logic signed [ACC_W-13:0] Q_MAX = (ACC_W-12)'(32767);
  localparam logic signed [ACC_W-13:0] Q_MIN = -(ACC_W-12)'(32768);

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [1:0] {
    KIND_WEIGHT  = 2'd0,
    KIND_BIAS    = 2'd1,
    KIND_FEATURE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  localparam logic [1:0] GATE_INPUT  = 2'd0;
  localparam logic [1:0] GATE_FORGET = 2'd1;
  localparam logic [1:0] GATE_CAND   = 2'd2;
  localparam logic [1:0] GATE_OUTPUT = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic [1:0]               gate;
    logic [ROW_W-1:0]         row;
    logic [UNIT_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic [UNIT_W-1:0]        unit_index;
    logic signed [DATA_W-1:0] hidden_value;
    logic                     final_res;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GATE, S_CELL_F, S_CELL_I, S_HMUL, S_DRAIN, S_ROUND, S_LUT, S_OUT, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_GATE, PH_CELL, PH_HID
  } phase_e;

  typedef enum logic [1:0] {
    SEL_W, SEL_BIAS, SEL_REG
  } sel_e;

  // Round to nearest (halves up) from Q.12 and clamp to 16 bits.
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]  t;
    logic signed [ACC_W-13:0] q;
    t = acc + ACC_W'(2048);
    q = t[ACC_W-1:12];
    if (q > Q_MAX) begin
      return DATA_W'(32767);
    end else if (q < Q_MIN) begin
      return -DATA_W'(32768);
    end
    return q[DATA_W-1:0];
  endfunction

  // Shift-subtract divide, used only while building constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-a/4096) in Q2.30 via short series and repeated squaring.
  function automatic logic [63:0] exp_neg(input logic [31:0] a);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    t = {32'd0, a} << 12;
    sum = ONE_Q30;
    term = ONE_Q30;
    for (int k = 1; k <= 10; k++) begin
      term = udiv64((term * t) >> 30, 64'(k));
      if (k % 2 == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    for (int k = 0; k < 6; k++) begin
      sum = (sum * sum + (64'd1 << 29)) >> 30;
    end
    return sum;
  endfunction

  function automatic int bin_mid(input int idx, input int depth);
    logic [63:0] num;
    num = 64'(2 * idx + 1) * 64'd32768;
    return -32768 + int'(udiv64(num, 64'(depth)));
  endfunction

  function automatic logic [DATA_W-1:0] sig_entry(input int idx, input int depth);
    int          m;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] r;
    m = bin_mid(idx, depth);
    e = exp_neg(32'((m < 0) ? -m : m));
    d = ONE_Q30 + e;
    num = (m >= 0) ? (ONE_Q30 << 12) : (e << 12);
    r = udiv64(num + (d >> 1), d);
    return r[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] tanh_entry(input int idx, input int depth);
    int          m;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] r;
    m = bin_mid(idx, depth);
    e = exp_neg(32'(2 * ((m < 0) ? -m : m)));
    d = ONE_Q30 + e;
    r = udiv64(((ONE_Q30 - e) << 12) + (d >> 1), d);
    return (m < 0) ? DATA_W'(-r) : r[DATA_W-1:0];
  endfunction

endpackage

@@ rtl/core/lcs_act_lut.sv @@
module lcs_act_lut #(
  parameter int ACT_TABLE_DEPTH = lcs_pkg::ACT_TABLE_DEPTH_DEF
) (
  input  logic signed [lcs_pkg::DATA_W-1:0] pre,
  input  logic                              is_tanh,
  output logic signed [lcs_pkg::DATA_W-1:0] act
);

  localparam int IDX_W = $clog2(ACT_TABLE_DEPTH);
  localparam int DEP_W = $clog2(ACT_TABLE_DEPTH + 1);

  logic [lcs_pkg::DATA_W-1:0] sig_tab  [ACT_TABLE_DEPTH];
  logic [lcs_pkg::DATA_W-1:0] tanh_tab [ACT_TABLE_DEPTH];
  logic [lcs_pkg::DATA_W-1:0] offset;
  logic [lcs_pkg::DATA_W+DEP_W-1:0] scaled;
  logic [IDX_W-1:0] idx;

  for (genvar i = 0; i < ACT_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [lcs_pkg::DATA_W-1:0] SigVal  = lcs_pkg::sig_entry(i, ACT_TABLE_DEPTH);
    localparam logic [lcs_pkg::DATA_W-1:0] TanhVal = lcs_pkg::tanh_entry(i, ACT_TABLE_DEPTH);
    assign sig_tab[i]  = SigVal;
    assign tanh_tab[i] = TanhVal;
  end

  // bin = ((pre + 32768) * depth) >> 16
  assign offset = pre ^ 16'h8000;
  assign scaled = (lcs_pkg::DATA_W+DEP_W)'(offset) * (lcs_pkg::DATA_W+DEP_W)'(ACT_TABLE_DEPTH);
  assign idx    = scaled[lcs_pkg::DATA_W +: IDX_W];
  assign act    = is_tanh ? tanh_tab[idx] : sig_tab[idx];

endmodule

@@ rtl/core/lstm_cell_step_core.sv @@
// Load, bias, feature-without-last and clear beats are taken in idle; busy stays low.
// A feature beat with last runs the step; ROWS = INPUT_COUNT+HIDDEN_COUNT products
// per gate, plus the bias, all go through the single shared MAC.
// One result beat per hidden unit; the receiver cannot stall, each beat shows on done
// for one cycle.
// Reset (rst, synchronous) zeroes hidden and cell state; weight memories are not cleared.
module lstm_cell_step_core #(
  parameter int INPUT_COUNT     = lcs_pkg::INPUT_COUNT_DEF,
  parameter int HIDDEN_COUNT    = lcs_pkg::HIDDEN_COUNT_DEF,
  parameter int ACT_TABLE_DEPTH = lcs_pkg::ACT_TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lcs_pkg::item_t   item,
  output logic             done,
  output lcs_pkg::result_t result
);

  `include "lstm_cell_step_core_macros.svh"

  localparam int ROWS   = INPUT_COUNT + HIDDEN_COUNT;
  localparam int WDEPTH = 4 * ROWS * HIDDEN_COUNT;
  localparam int BDEPTH = 4 * HIDDEN_COUNT;
  localparam int WA_W   = $clog2(WDEPTH);
  localparam int BA_W   = $clog2(BDEPTH);
  localparam int FI_W   = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int HI_W   = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int K_W    = $clog2(ROWS + 1);
  localparam int DW     = lcs_pkg::DATA_W;
  localparam int AW     = lcs_pkg::ACC_W;

  lcs_pkg::state_e state, state_next;
  lcs_pkg::phase_e phase;

  logic [K_W-1:0]  k;
  logic [K_W-1:0]  r;
  logic [1:0]      g;
  logic [HI_W-1:0] j;
  logic            drain;

  // storage
  logic signed [DW-1:0] weight_mem [WDEPTH];
  logic signed [DW-1:0] bias_mem   [BDEPTH];
  logic signed [DW-1:0] feat_mem   [INPUT_COUNT];
  logic signed [DW-1:0] hidden     [HIDDEN_COUNT];
  logic signed [DW-1:0] h_new      [HIDDEN_COUNT];
  logic signed [DW-1:0] cell_vec   [HIDDEN_COUNT];

  // per-unit gate activations
  logic signed [DW-1:0] ig, fg, cg, og, tanh_c;

  // MAC pipeline
  logic                 iss_vld, iss_clr;
  lcs_pkg::sel_e        iss_sel;
  logic                 iss_vld_r, iss_clr_r;
  lcs_pkg::sel_e        iss_sel_r;
  logic signed [DW-1:0] x_rd, y_rd, w_rd, b_rd;
  logic signed [DW-1:0] a_op, b_op;
  logic signed [2*DW-1:0] prod;
  logic                 prod_vld, prod_clr;
  logic signed [AW-1:0] acc;
  logic signed [DW-1:0] pre_r;
  logic signed [DW-1:0] act;
  logic                 act_tanh;

  logic            accept;
  logic [WA_W-1:0] waddr_rd, waddr_wr;
  logic [BA_W-1:0] baddr_rd, baddr_wr;

  assign accept = start && !busy;
  assign r      = k - K_W'(1);

  assign waddr_rd = WA_W'((int'(g) * ROWS + int'(r)) * HIDDEN_COUNT + int'(j));
  assign baddr_rd = BA_W'(int'(g) * HIDDEN_COUNT + int'(j));
  assign waddr_wr = WA_W'((int'(item.gate) * ROWS + int'(item.row)) * HIDDEN_COUNT
                          + int'(item.col));
  assign baddr_wr = BA_W'(int'(item.gate) * HIDDEN_COUNT + int'(item.col));

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      lcs_pkg::S_IDLE: begin
        if (accept && item.kind == lcs_pkg::KIND_FEATURE && item.last) begin
          state_next = lcs_pkg::S_GATE;
        end
      end
      lcs_pkg::S_GATE: begin
        if (k == K_W'(ROWS)) state_next = lcs_pkg::S_DRAIN;
      end
      lcs_pkg::S_CELL_F: state_next = lcs_pkg::S_CELL_I;
      lcs_pkg::S_CELL_I: state_next = lcs_pkg::S_DRAIN;
      lcs_pkg::S_HMUL:   state_next = lcs_pkg::S_DRAIN;
      lcs_pkg::S_DRAIN: begin
        if (drain) state_next = lcs_pkg::S_ROUND;
      end
      lcs_pkg::S_ROUND: begin
        state_next = (phase == lcs_pkg::PH_HID) ? lcs_pkg::S_OUT : lcs_pkg::S_LUT;
      end
      lcs_pkg::S_LUT: begin
        if (phase == lcs_pkg::PH_GATE) begin
          state_next = (g == lcs_pkg::GATE_OUTPUT) ? lcs_pkg::S_CELL_F : lcs_pkg::S_GATE;
        end else begin
          state_next = lcs_pkg::S_HMUL;
        end
      end
      lcs_pkg::S_OUT: begin
        state_next = (j == HI_W'(HIDDEN_COUNT - 1)) ? lcs_pkg::S_DONE : lcs_pkg::S_GATE;
      end
      lcs_pkg::S_DONE: state_next = lcs_pkg::S_IDLE;
      default: state_next = lcs_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs toward the MAC
  always_comb begin
    busy    = 1'b1;
    iss_vld = 1'b0;
    iss_clr = 1'b0;
    iss_sel = lcs_pkg::SEL_REG;
    case (state)
      lcs_pkg::S_IDLE: busy = 1'b0;
      lcs_pkg::S_GATE: begin
        iss_vld = 1'b1;
        iss_clr = (k == '0);
        iss_sel = (k == '0) ? lcs_pkg::SEL_BIAS : lcs_pkg::SEL_W;
      end
      lcs_pkg::S_CELL_F, lcs_pkg::S_HMUL: begin
        iss_vld = 1'b1;
        iss_clr = 1'b1;
      end
      lcs_pkg::S_CELL_I: iss_vld = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::S_IDLE;
      phase <= lcs_pkg::PH_GATE;
      k     <= '0;
      g     <= '0;
      j     <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        lcs_pkg::S_IDLE: begin
          k     <= '0;
          g     <= '0;
          j     <= '0;
          drain <= 1'b0;
        end
        lcs_pkg::S_GATE: begin
          phase <= lcs_pkg::PH_GATE;
          k     <= (k == K_W'(ROWS)) ? '0 : k + K_W'(1);
        end
        lcs_pkg::S_CELL_I: phase <= lcs_pkg::PH_CELL;
        lcs_pkg::S_HMUL:   phase <= lcs_pkg::PH_HID;
        lcs_pkg::S_DRAIN:  drain <= ~drain;
        lcs_pkg::S_LUT: begin
          if (phase == lcs_pkg::PH_GATE) g <= g + 2'd1;
        end
        lcs_pkg::S_OUT: j <= j + HI_W'(1);
        default: ;
      endcase
    end
  end

  // memory writes from load and feature beats
  always_ff @(posedge clk) begin
    if (accept && item.kind == lcs_pkg::KIND_WEIGHT
        && int'(item.row) < ROWS && int'(item.col) < HIDDEN_COUNT) begin
      weight_mem[waddr_wr] <= item.value;
    end
    if (accept && item.kind == lcs_pkg::KIND_BIAS && int'(item.col) < HIDDEN_COUNT) begin
      bias_mem[baddr_wr] <= item.value;
    end
    if (accept && item.kind == lcs_pkg::KIND_FEATURE && int'(item.row) < INPUT_COUNT) begin
      feat_mem[FI_W'(item.row)] <= item.value;
    end
  end

  // operand fetch: registered reads, one beat per cycle into the MAC while the sequencer issues
  always_ff @(posedge clk) begin
    w_rd <= weight_mem[waddr_rd];
    b_rd <= bias_mem[baddr_rd];
    case (state)
      lcs_pkg::S_GATE: begin
        if (r < K_W'(INPUT_COUNT)) begin
          x_rd <= feat_mem[FI_W'(r)];
        end else begin
          x_rd <= hidden[HI_W'(r - K_W'(INPUT_COUNT))];
        end
      end
      lcs_pkg::S_CELL_F: begin
        x_rd <= fg;
        y_rd <= cell_vec[j];
      end
      lcs_pkg::S_CELL_I: begin
        x_rd <= ig;
        y_rd <= cg;
      end
      lcs_pkg::S_HMUL: begin
        x_rd <= og;
        y_rd <= tanh_c;
      end
      default: ;
    endcase
  end

  // shared multiplier, then accumulator
  always_comb begin
    a_op = (iss_sel_r == lcs_pkg::SEL_BIAS) ? b_rd : x_rd;
    case (iss_sel_r)
      lcs_pkg::SEL_W:    b_op = w_rd;
      lcs_pkg::SEL_BIAS: b_op = DW'(4096);
      default:           b_op = y_rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_vld_r <= 1'b0;
      prod_vld  <= 1'b0;
    end else begin
      iss_vld_r <= iss_vld;
      prod_vld  <= iss_vld_r;
    end
    iss_clr_r <= iss_clr;
    iss_sel_r <= iss_sel;
    prod      <= a_op * b_op;
    prod_clr  <= iss_clr_r;
    if (prod_vld) begin
      acc <= prod_clr ? AW'(prod) : acc + AW'(prod);
    end
    if (state == lcs_pkg::S_ROUND) begin
      pre_r <= lcs_pkg::round_sat(acc);
    end
  end

  assign act_tanh = (phase == lcs_pkg::PH_CELL)
                 || (phase == lcs_pkg::PH_GATE && g == lcs_pkg::GATE_CAND);

  lcs_act_lut #(
    .ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)
  ) u_act (
    .pre     (pre_r),
    .is_tanh (act_tanh),
    .act     (act)
  );

  // gate latches, tanh of the cell value and new hidden value for the unit in flight
  always_ff @(posedge clk) begin
    if (state == lcs_pkg::S_LUT) begin
      if (phase == lcs_pkg::PH_GATE) begin
        case (g)
          lcs_pkg::GATE_INPUT:  ig <= act;
          lcs_pkg::GATE_FORGET: fg <= act;
          lcs_pkg::GATE_CAND:   cg <= act;
          default:              og <= act;
        endcase
      end else begin
        tanh_c <= act;
      end
    end
    if (state == lcs_pkg::S_OUT) begin
      h_new[j] <= pre_r;
    end
  end

  // hidden and cell state: cleared by reset and clear beats; hidden swaps at step end
  always_ff @(posedge clk) begin
    if (rst || (accept && item.kind == lcs_pkg::KIND_CLEAR)) begin
      hidden   <= '{default: '0};
      cell_vec <= '{default: '0};
    end else begin
      if (state == lcs_pkg::S_LUT && phase == lcs_pkg::PH_CELL) begin
        cell_vec[j] <= pre_r;
      end
      if (state == lcs_pkg::S_DONE) begin
        hidden <= h_new;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == lcs_pkg::S_OUT);
    end
    if (state == lcs_pkg::S_OUT) begin
      result.unit_index   <= lcs_pkg::UNIT_W'(j);
      result.hidden_value <= pre_r;
      result.final_res    <= (j == HI_W'(HIDDEN_COUNT - 1));
    end
  end

  `LCS_ASSERT_NOW(a_done_in_step, clk, rst, done, busy)
  `LCS_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `LCS_ASSERT_NEXT(a_final_ends, clk, rst, done && result.final_res, !busy)
  `LCS_ASSERT_NEXT(a_step_starts, clk, rst,
    accept && item.kind == lcs_pkg::KIND_FEATURE && item.last, busy)
  `LCS_ASSERT_NEXT(a_load_no_busy, clk, rst,
    accept && !(item.kind == lcs_pkg::KIND_FEATURE && item.last), !busy)

endmodule
